@@ hdl/crc16_uart_packet_framer_defines.svh @@
// assertion macros shared by the framer modules
`ifndef CRC16_UART_PACKET_FRAMER_DEFINES_SVH
`define CRC16_UART_PACKET_FRAMER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CRCPF_ASSERT_IMP(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("crcpf same-cycle check failed");

// next-cycle implication, checked out of reset
`define CRCPF_ASSERT_NXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("crcpf next-cycle check failed");

`endif

@@ hdl/crcpf_pkg.sv @@
// types, constants and crc function for the crc-16 uart packet framer
package crcpf_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CRC_W      = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned QDEPTH_DEF = 4;

  localparam logic [CRC_W-1:0]  CRC_POLY   = 16'h1021;
  localparam logic [BYTE_W-1:0] HEADER_RST = 8'hAA;
  localparam logic [BYTE_W-1:0] TAIL_RST   = 8'hBB;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL   = 1'b1;

  // pieces of a frame, in emission order
  typedef enum logic [2:0] {
    PC_HDR  = 3'd0,
    PC_LEN  = 3'd1,
    PC_DAT  = 3'd2,
    PC_CRCH = 3'd3,
    PC_CRCL = 3'd4,
    PC_TAIL = 3'd5
  } piece_t;

  localparam int unsigned NPIECE = 6;

  typedef logic [NPIECE-1:0] pmask_t;

  localparam pmask_t PM_HDR   = 6'b000001;
  localparam pmask_t PM_LEN   = 6'b000010;
  localparam pmask_t PM_DAT   = 6'b000100;
  localparam pmask_t PM_CLOSE = 6'b111000;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              start_of_frame;
    logic [BYTE_W-1:0] payload_length;
  } in_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              frame_end;
    logic              last_of_run;
  } out_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] header;
    logic [BYTE_W-1:0] tail;
  } cfg_t;

  // work handed from front to back: which pieces to send and their values
  typedef struct packed {
    pmask_t            mask;
    logic [BYTE_W-1:0] len_val;
    logic [BYTE_W-1:0] dat_val;
    logic [CRC_W-1:0]  crc;
  } job_t;

  // bitwise crc-16/xmodem update by one byte
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/crc16_uart_packet_framer.sv @@
// top level of the crc-16/xmodem uart packet framer
// path: an accepted beat's job passes the queue slot, the back end's current-job registers and the output register
// throughput: one output beat per cycle while out_stall is low; an input beat produces 0 to 6
// output bytes; input beats are taken every cycle while the QDEPTH-entry queue has room
// reset: synchronous active-low rst_n clears frame state, queue and output valid;
// header and tail registers return to 0xAA and 0xBB
module crc16_uart_packet_framer #(
  parameter int unsigned QDEPTH = crcpf_pkg::QDEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  crcpf_pkg::in_beat_t                  in_payload,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output crcpf_pkg::out_beat_t                 out_payload,
  input  logic                                 cfg_we,
  input  logic [crcpf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [crcpf_pkg::BYTE_W-1:0]         cfg_wdata
);
  import crcpf_pkg::*;

  cfg_t cfg_r;
  logic push;
  job_t push_job;
  logic pop;
  logic q_full;
  logic q_valid;
  job_t head_job;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header <= HEADER_RST;
      cfg_r.tail   <= TAIL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEADER: cfg_r.header <= cfg_wdata;
        REG_TAIL:   cfg_r.tail   <= cfg_wdata;
        default:    cfg_r        <= cfg_r;
      endcase
    end
  end

  crcpf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_payload (in_payload),
    .q_full     (q_full),
    .in_stall   (in_stall),
    .push       (push),
    .push_job   (push_job)
  );

  crcpf_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .q_valid  (q_valid),
    .head_job (head_job)
  );

  crcpf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_valid     (q_valid),
    .head_job    (head_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_payload (out_payload)
  );

endmodule

@@ hdl/crcpf_front.sv @@
// front end: accepts input beats, tracks frame state and crc, builds jobs
module crcpf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  crcpf_pkg::in_beat_t in_payload,
  input  logic                q_full,
  output logic                in_stall,
  output logic                push,
  output crcpf_pkg::job_t     push_job
);
  import crcpf_pkg::*;

  logic              in_frame_r, in_frame_nxt;
  logic [BYTE_W-1:0] remaining_r, remaining_nxt;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic              accept;
  logic [BYTE_W-1:0] rem_dec;
  job_t              job;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // classify the beat and compute the next frame state
  always_comb begin
    in_frame_nxt  = in_frame_r;
    remaining_nxt = remaining_r;
    crc_nxt       = crc_r;
    rem_dec       = (remaining_r != '0) ? remaining_r - 1'b1 : '0;
    job.mask      = '0;
    job.len_val   = in_payload.payload_length;
    job.dat_val   = in_payload.payload_byte;
    job.crc       = '0;
    if (in_payload.start_of_frame) begin
      job.mask = PM_HDR | PM_LEN;
      if (in_payload.payload_length == '0) begin
        crc_nxt       = '0;
        job.mask      = job.mask | PM_CLOSE;
        in_frame_nxt  = 1'b0;
        remaining_nxt = '0;
      end else begin
        crc_nxt       = crc_feed('0, in_payload.payload_byte);
        job.mask      = job.mask | PM_DAT;
        remaining_nxt = in_payload.payload_length - 1'b1;
        in_frame_nxt  = (remaining_nxt != '0);
        if (remaining_nxt == '0) begin
          job.mask = job.mask | PM_CLOSE;
        end
      end
    end else if (in_frame_r) begin
      crc_nxt       = crc_feed(crc_r, in_payload.payload_byte);
      job.mask      = PM_DAT;
      remaining_nxt = rem_dec;
      if (rem_dec == '0) begin
        job.mask     = job.mask | PM_CLOSE;
        in_frame_nxt = 1'b0;
      end
    end
    job.crc = crc_nxt;
  end

  assign push     = accept && (job.mask != '0);
  assign push_job = job;

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      remaining_r <= '0;
      crc_r       <= '0;
    end else if (accept) begin
      in_frame_r  <= in_frame_nxt;
      remaining_r <= remaining_nxt;
      crc_r       <= crc_nxt;
    end
  end

endmodule

@@ hdl/crcpf_queue.sv @@
// short job queue between front and back
module crcpf_queue #(
  parameter int unsigned DEPTH = crcpf_pkg::QDEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  crcpf_pkg::job_t push_job,
  input  logic            pop,
  output logic            full,
  output logic            q_valid,
  output crcpf_pkg::job_t head_job
);
  import crcpf_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign q_valid  = (count_r != '0);
  assign head_job = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

`include "crc16_uart_packet_framer_defines.svh"

  `CRCPF_ASSERT_IMP(a_no_pop_empty, pop, count_r != '0)
  `CRCPF_ASSERT_IMP(a_no_push_full, push, !full)
  `CRCPF_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH))

endmodule

@@ hdl/crcpf_back.sv @@
// back end: walks a job's pieces and sends one byte per beat
module crcpf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  crcpf_pkg::cfg_t      cfg,
  input  logic                 q_valid,
  input  crcpf_pkg::job_t      head_job,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output crcpf_pkg::out_beat_t out_payload
);
  import crcpf_pkg::*;

  pmask_t            cur_mask_r, cur_mask_nxt;
  logic [BYTE_W-1:0] cur_len_r;
  logic [BYTE_W-1:0] cur_dat_r;
  logic [CRC_W-1:0]  cur_crc_r;
  logic              out_valid_r;
  out_beat_t         out_r;
  logic              load_ok;
  logic              emit;
  piece_t            sel;
  pmask_t            mask_after;
  logic [BYTE_W-1:0] sel_byte;

  assign load_ok = !out_valid_r || !out_stall;
  assign emit    = load_ok && (cur_mask_r != '0);

  // pick the earliest pending piece
  always_comb begin
    sel = PC_HDR;
    for (int i = NPIECE - 1; i >= 0; i--) begin
      if (cur_mask_r[i]) begin
        sel = piece_t'(3'(i));
      end
    end
    mask_after      = cur_mask_r;
    mask_after[sel] = 1'b0;
  end

  // byte for the chosen piece
  always_comb begin
    case (sel)
      PC_HDR:  sel_byte = cfg.header;
      PC_LEN:  sel_byte = cur_len_r;
      PC_DAT:  sel_byte = cur_dat_r;
      PC_CRCH: sel_byte = cur_crc_r[CRC_W-1:BYTE_W];
      PC_CRCL: sel_byte = cur_crc_r[BYTE_W-1:0];
      PC_TAIL: sel_byte = cfg.tail;
      default: sel_byte = cfg.header;
    endcase
  end

  // take the next job once the current one is done or finishing
  assign pop = q_valid && ((cur_mask_r == '0) || (emit && (mask_after == '0)));

  always_comb begin
    cur_mask_nxt = cur_mask_r;
    if (pop) begin
      cur_mask_nxt = head_job.mask;
    end else if (emit) begin
      cur_mask_nxt = mask_after;
    end
  end

  // current job registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_mask_r <= '0;
    end else begin
      cur_mask_r <= cur_mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_len_r <= head_job.len_val;
      cur_dat_r <= head_job.dat_val;
      cur_crc_r <= head_job.crc;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r.out_byte    <= sel_byte;
      out_r.frame_end   <= (sel == PC_TAIL);
      out_r.last_of_run <= (mask_after == '0);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

`include "crc16_uart_packet_framer_defines.svh"

  `CRCPF_ASSERT_IMP(a_tail_ends_run, out_valid_r && out_r.frame_end, out_r.last_of_run)
  `CRCPF_ASSERT_NXT(a_pop_loads_work, pop, cur_mask_r != '0)
  `CRCPF_ASSERT_NXT(a_run_continues, out_valid_r && !out_stall && !out_r.last_of_run,
                    out_valid_r)

endmodule
